// File: rtl/msig_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msig_pkg: shared types and constants of the message signature tag block
// Holds the polynomial, mixing constants, score weights and the records that
// travel between the front end, the message engine and the tag mixer.
// ----------------------------------------------------------------------------
package msig_pkg;

    localparam int unsigned LANE_COUNT  = 10;
    localparam int unsigned LANE_PTR_W  = 4;
    localparam int unsigned BLOCK_COUNT = 16;
    localparam int unsigned BLOCK_NUM_W = 5;
    localparam int unsigned SIG_W       = 33;
    localparam int unsigned SCORE_W     = 7;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = 2;
    localparam int unsigned QCNT_W      = 3;

    localparam logic [31:0] REG_POLY   = 32'h1EDC6F41;
    localparam logic [31:0] MIX_C1     = 32'h7feb352d;
    localparam logic [31:0] MIX_C2     = 32'h846ca68b;
    localparam logic [31:0] LAYER_MUL  = 32'h9e3779b1;
    localparam logic [31:0] LENGTH_MUL = 32'h85ebca6b;

    localparam logic [SCORE_W-1:0] SCORE_DEP   = 7'd24;
    localparam logic [SCORE_W-1:0] SCORE_CKS   = 7'd20;
    localparam logic [SCORE_W-1:0] SCORE_PHI   = 7'd20;
    localparam logic [SCORE_W-1:0] SCORE_LANES = 7'd18;
    localparam logic [SCORE_W-1:0] SCORE_LEN   = 7'd18;

    // Per-byte record written by the front end into the queue.
    typedef struct packed {
        logic [7:0]         data_byte;
        logic [SCORE_W-1:0] base_score;
        logic [31:0]        layer_prod;
        logic [31:0]        len_prod;
    } item_meta_t;

    // Finished message handed from the engine to the tag mixer.
    typedef struct packed {
        logic [SIG_W-1:0]   sig;
        logic [SCORE_W-1:0] score;
        logic [31:0]        layer_prod;
        logic [31:0]        len_prod;
    } emit_t;

endpackage
`default_nettype wire

// File: rtl/message_signature_tag_top.sv
// Throughput: one byte transaction per cycle while the queue is not full, set by the
//   per-byte state update of the message engine; one result transaction per message.
// Path: the last byte of a message (or its empty-message transaction) passes the queue,
//   then the engine into the first mix stage, two multiply stages and the output register.
// Reset: asynchronous; empties the queue and pipeline and restores the message state.
`default_nettype none
// ----------------------------------------------------------------------------
// message_signature_tag_top: message signature, score and tag generator
// Accepts a message one byte per transaction and, at its end, returns a
// 33-bit signature, a 7-bit score and a 32-bit mixed tag.
// ----------------------------------------------------------------------------
module message_signature_tag_top #(
    parameter int unsigned LENGTH_BITS      = 24,
    parameter int unsigned DEPENDENCY_LIMIT = 64
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        item_valid,
    output logic                             item_stall,
    input  wire logic [7:0]                  data_byte,
    input  wire logic [23:0]                 message_length,
    input  wire logic [15:0]                 dependency_count,
    input  wire logic [31:0]                 entry_checksum,
    input  wire logic [31:0]                 entry_phi,
    input  wire logic [7:0]                  entry_layer,
    output logic                             result_valid,
    input  wire logic                        result_stall,
    output logic [msig_pkg::SIG_W-1:0]       signature,
    output logic [msig_pkg::SCORE_W-1:0]     score,
    output logic [31:0]                      tag
);
    import msig_pkg::*;

    // One queue entry carries the classified byte plus the trimmed length
    // and block size, which vary with the length parameter.
    localparam int unsigned QW = $bits(item_meta_t) + LENGTH_BITS + (LENGTH_BITS - 3);

    item_meta_t             front_meta;
    logic [LENGTH_BITS-1:0] front_len;
    logic [LENGTH_BITS-4:0] front_bsize;

    logic                   q_full;
    logic                   q_not_empty;
    logic [QW-1:0]          q_head;
    logic                   q_pop;

    item_meta_t             head_meta;
    logic [LENGTH_BITS-1:0] head_len;
    logic [LENGTH_BITS-4:0] head_bsize;

    emit_t                  emit;
    logic                   emit_valid;
    logic                   emit_ready;

    // The front end only classifies; the queue decides acceptance.
    msig_front #(
        .LENGTH_BITS      (LENGTH_BITS),
        .DEPENDENCY_LIMIT (DEPENDENCY_LIMIT)
    ) u_front (
        .data_byte        (data_byte),
        .message_length   (message_length),
        .dependency_count (dependency_count),
        .entry_checksum   (entry_checksum),
        .entry_phi        (entry_phi),
        .entry_layer      (entry_layer),
        .meta             (front_meta),
        .len              (front_len),
        .bsize            (front_bsize)
    );

    // Input transactions stall only when the queue is full, so the front
    // keeps taking bytes while a result waits at the output.
    assign item_stall = q_full;

    msig_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_valid  (item_valid),
        .wr_data   ({front_meta, front_len, front_bsize}),
        .full      (q_full),
        .rd_en     (q_pop),
        .not_empty (q_not_empty),
        .rd_data   (q_head)
    );

    assign {head_meta, head_len, head_bsize} = q_head;

    // The engine retires one byte a cycle and holds a message end until
    // the mixer has room for it.
    msig_engine #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_not_empty),
        .head_meta  (head_meta),
        .head_len   (head_len),
        .head_bsize (head_bsize),
        .pop        (q_pop),
        .emit_valid (emit_valid),
        .emit       (emit),
        .emit_ready (emit_ready)
    );

    // The mixer ends in the output register that drives the result channel.
    msig_mix u_mix (
        .clk          (clk),
        .rst_n        (rst_n),
        .emit_valid   (emit_valid),
        .emit         (emit),
        .emit_ready   (emit_ready),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .signature    (signature),
        .score        (score),
        .tag          (tag)
    );

endmodule
`default_nettype wire

// File: rtl/msig_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msig_front: input classification
// Trims the length, computes the block size, the item-only part of the score
// and the two tag products, and packs them into a queue entry.
// ----------------------------------------------------------------------------
module msig_front #(
    parameter int unsigned LENGTH_BITS      = 24,
    parameter int unsigned DEPENDENCY_LIMIT = 64
) (
    input  wire logic [7:0]                 data_byte,
    input  wire logic [23:0]                message_length,
    input  wire logic [15:0]                dependency_count,
    input  wire logic [31:0]                entry_checksum,
    input  wire logic [31:0]                entry_phi,
    input  wire logic [7:0]                 entry_layer,
    output msig_pkg::item_meta_t            meta,
    output logic [LENGTH_BITS-1:0]          len,
    output logic [LENGTH_BITS-4:0]          bsize
);
    import msig_pkg::*;

    logic [LENGTH_BITS:0] len_round;

    always_comb
    begin
        len       = LENGTH_BITS'(message_length);
        // Block size is the length divided by sixteen, rounded up.
        len_round = {1'b0, len} + (LENGTH_BITS+1)'(15);
        bsize     = len_round[LENGTH_BITS:4];

        meta.data_byte  = data_byte;
        meta.base_score = ((dependency_count <= 16'(DEPENDENCY_LIMIT)) ? SCORE_DEP : '0)
                        + ((entry_checksum != '0) ? SCORE_CKS : '0)
                        + ((entry_phi != '0) ? SCORE_PHI : '0)
                        + ((len != '0) ? SCORE_LEN : '0);
        meta.layer_prod = 32'(32'(entry_layer) * LAYER_MUL);
        meta.len_prod   = 32'(32'(len) * LENGTH_MUL);
    end

endmodule
`default_nettype wire

// File: rtl/msig_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msig_queue: short FIFO between the front end and the message engine
// Four entries in flip-flops; the head entry is presented combinationally.
// ----------------------------------------------------------------------------
module msig_queue #(
    parameter int unsigned WIDTH = 96
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_valid,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             rd_en,
    output logic                  not_empty,
    output logic [WIDTH-1:0]      rd_data
);
    import msig_pkg::*;

    logic [WIDTH-1:0]  entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              wr_en;

    always_comb
    begin
        full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
        not_empty = (count_reg != '0);
        rd_data   = entry_reg[rd_ptr_reg];
        wr_en     = wr_valid && !full;
        count_next = count_reg + QCNT_W'(wr_en) - QCNT_W'(rd_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count exceeds depth");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> count_reg != '0)
        else $error("queue read while empty");
`endif

endmodule
`default_nettype wire

// File: rtl/msig_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msig_engine: per-byte message state update
// Folds one queued byte per cycle into the lanes, block parities and the shift register,
// and hands the signature and score on at the message end, held until the mixer has room.
// ----------------------------------------------------------------------------
module msig_engine #(
    parameter int unsigned LENGTH_BITS = 24
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   head_valid,
    input  wire msig_pkg::item_meta_t   head_meta,
    input  wire logic [LENGTH_BITS-1:0] head_len,
    input  wire logic [LENGTH_BITS-4:0] head_bsize,
    output logic                        pop,
    output logic                        emit_valid,
    output msig_pkg::emit_t             emit,
    input  wire logic                   emit_ready
);
    import msig_pkg::*;

    logic [7:0]             lane_reg [LANE_COUNT];
    logic [7:0]             lane_next [LANE_COUNT];
    logic [LANE_PTR_W-1:0]  lane_ptr_reg;
    logic [LANE_PTR_W-1:0]  lane_ptr_next;
    logic [31:0]            shift_reg;
    logic [31:0]            shift_next;
    logic [7:0]             block_xor_reg;
    logic [7:0]             block_xor_next;
    logic [BLOCK_COUNT-1:0] block_flags_reg;
    logic [BLOCK_COUNT-1:0] block_flags_next;
    logic [BLOCK_NUM_W-1:0] block_num_reg;
    logic [BLOCK_NUM_W-1:0] block_num_next;
    logic [LENGTH_BITS-1:0] offset_reg;
    logic [LENGTH_BITS-1:0] offset_next;
    logic [LENGTH_BITS-1:0] seen_reg;
    logic [LENGTH_BITS-1:0] seen_next;

    logic [7:0]             lane_upd [LANE_COUNT];
    logic [LANE_COUNT-1:0]  lanes_nz;
    logic [31:0]            shift_in;
    logic [31:0]            shift_upd;
    logic [7:0]             bxor_upd;
    logic [BLOCK_COUNT-1:0] flags_upd;
    logic [BLOCK_NUM_W-1:0] bnum_upd;
    logic [LENGTH_BITS-1:0] off_inc;
    logic [LENGTH_BITS-1:0] seen_inc;
    logic                   len_zero;
    logic                   last;
    logic                   close_block;
    logic                   ends;

    always_comb
    begin
        for (int i = 0; i < LANE_COUNT; i++)
        begin
            lane_upd[i] = lane_reg[i] ^
                ((lane_ptr_reg == LANE_PTR_W'(i)) ? head_meta.data_byte : 8'h00);
            lanes_nz[i] = (lane_upd[i] != '0);
        end

        shift_in  = shift_reg ^ {head_meta.data_byte, 24'h000000};
        shift_upd = {shift_in[30:0], 1'b0} ^ (shift_in[31] ? REG_POLY : 32'h0);

        bxor_upd = block_xor_reg ^ head_meta.data_byte;
        off_inc  = offset_reg + 1'b1;
        seen_inc = seen_reg + 1'b1;

        len_zero    = (head_len == '0);
        // A wrapped byte count also ends the message.
        last        = (seen_inc >= head_len) || (seen_inc == '0);
        close_block = (off_inc >= LENGTH_BITS'(head_bsize)) || last;
        ends        = len_zero || last;

        flags_upd = block_flags_reg;
        bnum_upd  = block_num_reg;
        if (close_block && (block_num_reg < BLOCK_NUM_W'(BLOCK_COUNT)))
        begin
            if (bxor_upd != '0)
            begin
                flags_upd[block_num_reg[BLOCK_NUM_W-2:0]] = 1'b1;
            end
            bnum_upd = block_num_reg + 1'b1;
        end

        // An empty message reports the cleared state.
        emit.sig        = len_zero ? {REG_POLY[31:25], {(BLOCK_COUNT+LANE_COUNT){1'b0}}}
                                   : {shift_upd[31:25], flags_upd, lanes_nz};
        emit.score      = head_meta.base_score +
                          ((!len_zero && (lanes_nz != '0)) ? SCORE_LANES : '0);
        emit.layer_prod = head_meta.layer_prod;
        emit.len_prod   = head_meta.len_prod;

        pop        = head_valid && (!ends || emit_ready);
        emit_valid = head_valid && ends;

        lane_next        = lane_reg;
        lane_ptr_next    = lane_ptr_reg;
        shift_next       = shift_reg;
        block_xor_next   = block_xor_reg;
        block_flags_next = block_flags_reg;
        block_num_next   = block_num_reg;
        offset_next      = offset_reg;
        seen_next        = seen_reg;

        if (pop)
        begin
            if (ends)
            begin
                for (int i = 0; i < LANE_COUNT; i++)
                begin
                    lane_next[i] = '0;
                end
                lane_ptr_next    = '0;
                shift_next       = REG_POLY;
                block_xor_next   = '0;
                block_flags_next = '0;
                block_num_next   = '0;
                offset_next      = '0;
                seen_next        = '0;
            end
            else
            begin
                lane_next        = lane_upd;
                lane_ptr_next    = (lane_ptr_reg == LANE_PTR_W'(LANE_COUNT - 1)) ?
                                   '0 : lane_ptr_reg + 1'b1;
                shift_next       = shift_upd;
                block_flags_next = flags_upd;
                block_num_next   = bnum_upd;
                block_xor_next   = close_block ? '0 : bxor_upd;
                offset_next      = close_block ? '0 : off_inc;
                seen_next        = seen_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LANE_COUNT; i++)
            begin
                lane_reg[i] <= '0;
            end
            lane_ptr_reg    <= '0;
            shift_reg       <= REG_POLY;
            block_xor_reg   <= '0;
            block_flags_reg <= '0;
            block_num_reg   <= '0;
            offset_reg      <= '0;
            seen_reg        <= '0;
        end
        else
        begin
            lane_reg        <= lane_next;
            lane_ptr_reg    <= lane_ptr_next;
            shift_reg       <= shift_next;
            block_xor_reg   <= block_xor_next;
            block_flags_reg <= block_flags_next;
            block_num_reg   <= block_num_next;
            offset_reg      <= offset_next;
            seen_reg        <= seen_next;
        end
    end

`ifndef SYNTH
    a_block_num_bound: assert property (@(posedge clk) disable iff (!rst_n)
        block_num_reg <= BLOCK_NUM_W'(BLOCK_COUNT))
        else $error("block number beyond sixteen");
    a_lane_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        lane_ptr_reg < LANE_PTR_W'(LANE_COUNT))
        else $error("lane pointer out of range");
    a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && emit_valid) |=> (seen_reg == '0) && (lane_ptr_reg == '0)
                                && (block_num_reg == '0))
        else $error("message state not cleared after a finished message");
`endif

endmodule
`default_nettype wire

// File: rtl/msig_mix.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msig_mix: tag finalizer pipeline and output register
// Combines signature, score and products, then runs the two-multiply
// finalizer over three registered stages into the result register.
// ----------------------------------------------------------------------------
module msig_mix (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            emit_valid,
    input  wire msig_pkg::emit_t                 emit,
    output logic                                 emit_ready,
    output logic                                 result_valid,
    input  wire logic                            result_stall,
    output logic [msig_pkg::SIG_W-1:0]           signature,
    output logic [msig_pkg::SCORE_W-1:0]         score,
    output logic [31:0]                          tag
);
    import msig_pkg::*;

    logic               s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    logic [31:0]        s1_x_reg, s2_m_reg, s3_m_reg, tag_reg;
    logic [SIG_W-1:0]   s1_sig_reg, s2_sig_reg, s3_sig_reg, sig_reg;
    logic [SCORE_W-1:0] s1_score_reg, s2_score_reg, s3_score_reg, score_reg;

    logic        s1_ready, s2_ready, s3_ready, out_ready;
    logic [31:0] x_raw, x_next, m1_next, y_mid, m2_next, tag_next;

    always_comb
    begin
        out_ready = !out_valid_reg || !result_stall;
        s3_ready  = !s3_valid_reg || out_ready;
        s2_ready  = !s2_valid_reg || s3_ready;
        s1_ready  = !s1_valid_reg || s2_ready;
        emit_ready = s1_ready;

        x_raw = emit.sig[31:0] ^ {31'b0, emit.sig[SIG_W-1]} ^ emit.layer_prod
              ^ {1'b0, emit.score, 24'h000000} ^ emit.len_prod;
        x_next   = x_raw ^ (x_raw >> 16);
        m1_next  = s1_x_reg * MIX_C1;
        y_mid    = s2_m_reg ^ (s2_m_reg >> 15);
        m2_next  = y_mid * MIX_C2;
        tag_next = s3_m_reg ^ (s3_m_reg >> 16);

        result_valid = out_valid_reg;
        signature    = sig_reg;
        score        = score_reg;
        tag          = tag_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= emit_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (out_ready)
            begin
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && emit_valid)
        begin
            s1_x_reg     <= x_next;
            s1_sig_reg   <= emit.sig;
            s1_score_reg <= emit.score;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_m_reg     <= m1_next;
            s2_sig_reg   <= s1_sig_reg;
            s2_score_reg <= s1_score_reg;
        end
        if (s3_ready && s2_valid_reg)
        begin
            s3_m_reg     <= m2_next;
            s3_sig_reg   <= s2_sig_reg;
            s3_score_reg <= s2_score_reg;
        end
        if (out_ready && s3_valid_reg)
        begin
            tag_reg   <= tag_next;
            sig_reg   <= s3_sig_reg;
            score_reg <= s3_score_reg;
        end
    end

endmodule
`default_nettype wire

// File: bench/msig_check_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msig_check_pkg: expected results for the message signature tag bench
// Follows the per-message lane, block and shift register state one byte
// transaction at a time and checks every finished message against it.
// ----------------------------------------------------------------------------
package msig_check_pkg;

    import msig_pkg::SIG_W;
    import msig_pkg::SCORE_W;

    localparam int unsigned LANES     = 10;
    localparam int unsigned BLOCKS    = 16;
    localparam int unsigned DEP_LIMIT = 64;
    localparam int unsigned SCORE_MAX = 127;

    localparam bit [31:0] CRC_POLY   = 32'h1EDC6F41;
    localparam bit [31:0] AVAL_MUL_A = 32'h7feb352d;
    localparam bit [31:0] AVAL_MUL_B = 32'h846ca68b;
    localparam bit [31:0] LAYER_GOLD = 32'h9e3779b1;
    localparam bit [31:0] LEN_SPREAD = 32'h85ebca6b;

    localparam int unsigned PTS_DEPS  = 24;
    localparam int unsigned PTS_CKS   = 20;
    localparam int unsigned PTS_PHI   = 20;
    localparam int unsigned PTS_LANES = 18;
    localparam int unsigned PTS_LEN   = 18;

    typedef struct {
        bit [7:0]  data_byte;
        bit [23:0] length;
        bit [15:0] deps;
        bit [31:0] checksum;
        bit [31:0] phi;
        bit [7:0]  layer;
    } byte_txn_t;

    typedef struct {
        bit [SIG_W-1:0]   sig;
        bit [SCORE_W-1:0] score;
        bit [31:0]        tag;
    } msg_result_t;

    class signature_scoreboard;
        bit [7:0]    lane_acc[LANES];
        bit [31:0]   crc_reg;
        bit [7:0]    block_acc;
        bit [15:0]   block_marks;
        bit [4:0]    block_idx;
        bit [23:0]   block_off;
        bit [23:0]   byte_count;
        bit [3:0]    lane_idx;
        msg_result_t expected_results[$];
        int unsigned results_due;
        int unsigned mismatch_count;

        function new();
            restart();
            results_due    = 0;
            mismatch_count = 0;
        endfunction

        function void restart();
            foreach (lane_acc[i]) lane_acc[i] = '0;
            crc_reg     = CRC_POLY;
            block_acc   = '0;
            block_marks = '0;
            block_idx   = '0;
            block_off   = '0;
            byte_count  = '0;
            lane_idx    = '0;
        endfunction

        // Signature, score and tag of the message that closes with this transaction.
        function msg_result_t seal(byte_txn_t t, bit [23:0] len);
            msg_result_t r;
            bit [9:0]    lanes;
            int unsigned total;
            bit [31:0]   x;
            foreach (lane_acc[i]) lanes[i] = (lane_acc[i] != 0);
            r.sig = {crc_reg[31:25], block_marks, lanes};
            total = 0;
            if (t.deps <= DEP_LIMIT) total += PTS_DEPS;
            if (t.checksum != 0) total += PTS_CKS;
            if (t.phi != 0) total += PTS_PHI;
            if (lanes != 0) total += PTS_LANES;
            if (len != 0) total += PTS_LEN;
            if (total > SCORE_MAX) total = SCORE_MAX;
            r.score = SCORE_W'(total);
            x = r.sig[31:0] ^ {31'd0, r.sig[32]};
            x ^= 32'(t.layer) * LAYER_GOLD;
            x ^= {1'b0, r.score, 24'd0};
            x ^= 32'(len) * LEN_SPREAD;
            x ^= x >> 16;
            x *= AVAL_MUL_A;
            x ^= x >> 15;
            x *= AVAL_MUL_B;
            x ^= x >> 16;
            r.tag = x;
            return r;
        endfunction

        function void absorb_byte(byte_txn_t t);
            bit [24:0] span;
            bit        last;
            if (t.length == 0) begin
                // An empty message drops whatever was collected so far.
                restart();
                expected_results.push_back(seal(t, 24'd0));
                results_due++;
                restart();
                return;
            end
            span = ({1'b0, t.length} + 25'd15) / 25'd16;
            if (lane_idx >= LANES) lane_idx = '0;
            lane_acc[lane_idx] ^= t.data_byte;
            lane_idx++;
            if (lane_idx >= LANES) lane_idx = '0;
            crc_reg ^= {t.data_byte, 24'd0};
            crc_reg = crc_reg[31] ? ((crc_reg << 1) ^ CRC_POLY) : (crc_reg << 1);
            block_acc ^= t.data_byte;
            block_off++;
            byte_count++;
            last = (byte_count >= t.length) || (byte_count == 0);
            if (({1'b0, block_off} >= span) || last) begin
                if (block_idx < BLOCKS && block_acc != 0) block_marks[block_idx] = 1'b1;
                if (block_idx < BLOCKS) block_idx++;
                block_acc = '0;
                block_off = '0;
            end
            if (last) begin
                expected_results.push_back(seal(t, t.length));
                results_due++;
                restart();
            end
        endfunction

        function void compare_result(logic [SIG_W-1:0] sig, logic [SCORE_W-1:0] score,
                                     logic [31:0] tag);
            msg_result_t want;
            if (expected_results.size() == 0) begin
                $error("result transaction with no message pending: signature %h", sig);
                mismatch_count++;
                return;
            end
            want = expected_results.pop_front();
            if (sig !== want.sig) begin
                $error("signature: expected %h, got %h", want.sig, sig);
                mismatch_count++;
            end
            if (score !== want.score) begin
                $error("score: expected %0d, got %0d", want.score, score);
                mismatch_count++;
            end
            if (tag !== want.tag) begin
                $error("tag: expected %h, got %h", want.tag, tag);
                mismatch_count++;
            end
        endfunction
    endclass

endpackage
`default_nettype wire

// File: bench/tb_message_signature_tag_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_message_signature_tag_top: self-checking bench for the signature tag block
// Streams directed and random messages into the block with random gaps and
// back-pressure on both sides, predicts every finished message and compares
// signature, score and tag of each result transaction in order.
// ----------------------------------------------------------------------------
module tb_message_signature_tag_top;

    import msig_check_pkg::*;

    // Stimulus sizing. Most random messages are short so that plenty of
    // results come out; a few are long enough to use every block.
    localparam int unsigned RANDOM_ITEMS = 1120;
    localparam int unsigned STEADY_ITEMS = 150;
    localparam int unsigned HOLD_AT_ITEM = 450;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned IDLE_PERCENT = 30;

    // The result of a message has only the queue and the mixer stages to pass after its
    // last byte, so a short drain is enough to catch a stray extra result.
    localparam int unsigned DRAIN_CYCLES = 16;

    // Longest correct stretch without any transaction is the receiver hold-off
    // plus a few random stalls; the limit leaves a wide margin over that.
    localparam int unsigned STALL_LIMIT  = 2000;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          item_valid;
    logic                          item_stall;
    logic [7:0]                    data_byte;
    logic [23:0]                   message_length;
    logic [15:0]                   dependency_count;
    logic [31:0]                   entry_checksum;
    logic [31:0]                   entry_phi;
    logic [7:0]                    entry_layer;
    logic                          result_valid;
    logic                          result_stall;
    logic [msig_pkg::SIG_W-1:0]    signature;
    logic [msig_pkg::SCORE_W-1:0]  score;
    logic [31:0]                   tag;

    signature_scoreboard tracker;
    byte_txn_t           seen_txn;
    int unsigned         items_sent   = 0;
    int unsigned         quiet_cycles = 0;

    // Shared between the sender and the receiver: steady_run switches random
    // idling off on both sides, hold_request starts the long receiver hold-off.
    bit                  steady_run   = 1'b0;
    bit                  hold_request = 1'b0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    message_signature_tag_top u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .item_valid       (item_valid),
        .item_stall       (item_stall),
        .data_byte        (data_byte),
        .message_length   (message_length),
        .dependency_count (dependency_count),
        .entry_checksum   (entry_checksum),
        .entry_phi        (entry_phi),
        .entry_layer      (entry_layer),
        .result_valid     (result_valid),
        .result_stall     (result_stall),
        .signature        (signature),
        .score            (score),
        .tag              (tag)
    );

    // Random content for one byte transaction of a message of the given
    // length. Zero bytes, zero entry words and dependency counts near the
    // limit come up often enough to hit both sides of every score check.
    function automatic byte_txn_t random_txn(input bit [23:0] len);
        byte_txn_t t;
        t.data_byte = ($urandom_range(9) == 0) ? 8'h00 : 8'($urandom);
        t.length    = len;
        t.deps      = ($urandom_range(1) == 0) ? 16'($urandom_range(80)) : 16'($urandom);
        t.checksum  = ($urandom_range(3) == 0) ? 32'd0 : $urandom;
        t.phi       = ($urandom_range(3) == 0) ? 32'd0 : $urandom;
        t.layer     = 8'($urandom);
        return t;
    endfunction

    // Offers one transaction. Inputs change only at the falling edge; the
    // payload stays put while the block stalls, and the task returns at the
    // falling edge after the accepting rising edge, so valid is never lowered
    // and raised again within one time step.
    task automatic send_byte(input byte_txn_t t);
        while (!steady_run && $urandom_range(99) < IDLE_PERCENT) begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid       <= 1'b1;
        data_byte        <= t.data_byte;
        message_length   <= t.length;
        dependency_count <= t.deps;
        entry_checksum   <= t.checksum;
        entry_phi        <= t.phi;
        entry_layer      <= t.layer;
        @(posedge clk);
        while (item_stall) @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic send_run(input bit [23:0] len, input int unsigned count);
        repeat (count) send_byte(random_txn(len));
    endtask

    // Monitor: every accepted byte goes to the predictor, every accepted
    // result is checked against the oldest pending message. Both sides are
    // sampled at the rising edge, where the inputs have been stable since the
    // falling edge before.
    always @(posedge clk) begin
        if (rst_n) begin
            if (item_valid && !item_stall) begin
                seen_txn.data_byte = data_byte;
                seen_txn.length    = message_length;
                seen_txn.deps      = dependency_count;
                seen_txn.checksum  = entry_checksum;
                seen_txn.phi       = entry_phi;
                seen_txn.layer     = entry_layer;
                tracker.absorb_byte(seen_txn);
            end
            if (result_valid && !result_stall) tracker.compare_result(signature, score, tag);
        end
    end

    // Watchdog: a run in which no transaction moves on either side for too
    // long is hung and ends as a failure.
    always @(posedge clk) begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles == STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Receiver: random stalls, none during the steady stretch, and once a
    // long hold-off that lets the block fill up and push back on its input.
    initial begin
        int unsigned hold_left;
        result_stall = 1'b0;
        hold_left    = 0;
        forever begin
            @(negedge clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                result_stall <= 1'b1;
            end else if (steady_run)
                result_stall <= 1'b0;
            else
                result_stall <= ($urandom_range(99) < IDLE_PERCENT);
        end
    end

    // Sender and run control.
    initial begin
        byte_txn_t   t;
        bit [23:0]   len;
        int unsigned pick;
        int unsigned sel;
        int unsigned done;
        int unsigned first_random;
        bit          hold_issued;

        rst_n            = 1'b0;
        item_valid       = 1'b0;
        data_byte        = '0;
        message_length   = '0;
        dependency_count = '0;
        entry_checksum   = '0;
        entry_phi        = '0;
        entry_layer      = '0;
        hold_issued      = 1'b0;
        tracker          = new();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part. A byte of a message with the largest length is cut
        // off by an empty message, which must drop it and restart clean.
        send_run(24'hFFFFFF, 1);
        t = '{8'hFF, 24'd0, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF};
        send_byte(t);
        t = '{8'h00, 24'd0, 16'd0, 32'd0, 32'd0, 8'h00};
        send_byte(t);

        // Single-byte messages on both sides of the dependency limit; the
        // zero byte leaves every lane empty.
        t = '{8'h00, 24'd1, 16'd64, 32'd0, 32'd1, 8'h00};
        send_byte(t);
        t = '{8'hFF, 24'd1, 16'd65, 32'd1, 32'd0, 8'hFF};
        send_byte(t);

        // The length shrinks to the byte count, so the message ends at once.
        send_run(24'd30, 1);
        send_run(24'd2, 1);

        // Fifteen one-byte blocks, then the length grows to two-byte blocks:
        // the seventeenth block runs past the sixteen parity flags.
        send_run(24'd16, 15);
        send_run(24'd18, 3);

        // Random part. It opens with a stretch without any idling and
        // requests the receiver hold-off further in.
        first_random = items_sent;
        steady_run   = 1'b1;
        while (items_sent - first_random < RANDOM_ITEMS)
        begin
            if (steady_run && items_sent - first_random >= STEADY_ITEMS) steady_run = 1'b0;
            if (!hold_issued && items_sent - first_random >= HOLD_AT_ITEM) begin
                hold_request = 1'b1;
                hold_issued  = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 60) begin
                // Well-formed message, mostly short.
                sel = $urandom_range(99);
                len = (sel < 75) ? 24'($urandom_range(16, 1)) :
                      (sel < 95) ? 24'($urandom_range(64, 17)) :
                                   24'($urandom_range(300, 65));
                send_run(len, len);
            end else if (pick < 70) begin
                send_run(24'd0, 1);
            end else if (pick < 80) begin
                // A long message abandoned by an empty one; this also walks
                // every bit of the length field.
                len = 24'($urandom_range(24'hFFFFFF, 64));
                send_run(len, $urandom_range(8, 1));
                send_run(24'd0, 1);
            end else begin
                // The length changes partway through a message.
                len  = 24'($urandom_range(60, 2));
                done = $urandom_range(len - 1, 1);
                send_run(len, done);
                len = 24'($urandom_range(60, 1));
                send_run(len, (len > done) ? len - done : 1);
            end
        end
        steady_run = 1'b0;
        item_valid <= 1'b0;

        // Let every pending result arrive, then watch a little longer for
        // any result that should not be there.
        while (tracker.expected_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
`default_nettype wire

// File: message_signature_tag_top.f
rtl/msig_pkg.sv
rtl/msig_front.sv
rtl/msig_queue.sv
rtl/msig_engine.sv
rtl/msig_mix.sv
rtl/message_signature_tag_top.sv
bench/msig_check_pkg.sv
bench/tb_message_signature_tag_top.sv
